FILE: rtl/core/tscc_pkg.sv
// Shared types, constants and a helper function for the tensor shape compatibility checker.
package tscc_pkg;

	// Fixed field geometry of one operand request.
	localparam int LANES    = 8;
	localparam int RANK_W   = 4;
	localparam int IDX_W    = 3;
	localparam int DIM_IN_W = 32;
	localparam int STATUS_W = 2;
	localparam int EXP_W    = 32;

	// Stream widths; the data widths are padded to whole bytes.
	localparam int S_TDATA_W = 264;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 40;

	// Bit positions in s_tuser.
	localparam int TUSER_START  = 0;
	localparam int TUSER_RANKED = 1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_RANK = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_DIM  = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;   // capture the accepted operand request
		logic commit; // update the shape state and load the result register
	} cmd_t;

	// Index of the lowest set bit of a lane vector (zero when none is set).
	function automatic logic [IDX_W-1:0] lowest_index(input logic [LANES-1:0] vec);
		logic [IDX_W-1:0] idx;
		idx = '0;
		for (int i = LANES - 1; i >= 0; i--) begin
			if (vec[i]) begin
				idx = IDX_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

FILE: rtl/core/tscc_ctrl.sv
// Handshake controller: holds one operand request and schedules its commit.
module tscc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	output tscc_pkg::cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_HOLD = 1'b1;

	logic state_q;
	logic state_d;
	logic out_valid_q;
	logic commit;
	logic load;

	// A held request commits as soon as the result register is free or being drained.
	assign commit   = (state_q == ST_HOLD) && (!out_valid_q || m_tready);
	assign s_tready = (state_q == ST_IDLE) || commit;
	assign load     = s_tvalid && s_tready;

	assign cmd.load   = load;
	assign cmd.commit = commit;
	assign m_tvalid   = out_valid_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (load) begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (load) begin
					state_d = ST_HOLD;
				end else if (commit) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/core/tscc_datapath.sv
// Datapath: operand register, stored shape, per-lane compares, first-mismatch pick, result register.
module tscc_datapath #(
	parameter int MAX_RANK = 8,
	parameter int DIM_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tscc_pkg::cmd_t                   cmd,
	input  logic                             cfg_valid,
	input  logic                             cfg_data,
	input  logic [tscc_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic [tscc_pkg::S_TUSER_W-1:0]   s_tuser,
	output logic [tscc_pkg::M_TDATA_W-1:0]   m_tdata
);

	localparam int LANES  = tscc_pkg::LANES;
	localparam int RANK_W = tscc_pkg::RANK_W;
	localparam int IDX_W  = tscc_pkg::IDX_W;
	localparam int DIN_W  = tscc_pkg::DIM_IN_W;
	localparam int STAT_W = tscc_pkg::STATUS_W;
	localparam int EXP_W  = tscc_pkg::EXP_W;
	localparam logic [DIM_BITS-1:0] DIM_UNK = '1;

	// Configuration.
	logic allow_q;

	// Captured operand request.
	logic                start_q;
	logic                ranked_q;
	logic [RANK_W-1:0]   rank_q;
	logic [DIN_W-1:0]    dim_in_q [LANES];

	// Shape state of the current list.
	logic                rank_known_q;
	logic [RANK_W-1:0]   stored_rank_q;
	logic [DIM_BITS-1:0] stored_dims_q [LANES];
	logic                mask_active_q;
	logic [IDX_W-1:0]    masked_dim_q;
	logic [STAT_W-1:0]   err_status_q;
	logic [IDX_W-1:0]    err_index_q;
	logic [EXP_W-1:0]    err_expected_q;

	// Result register.
	logic [STAT_W-1:0]   res_status_q;
	logic [IDX_W-1:0]    res_index_q;
	logic [EXP_W-1:0]    res_expected_q;

	// State as seen by this request, after an optional start of list.
	logic                rk_e;
	logic [RANK_W-1:0]   srank_e;
	logic [DIM_BITS-1:0] sdim_e [LANES];
	logic                mask_e;
	logic [IDX_W-1:0]    masked_e;
	logic [STAT_W-1:0]   err_e;
	logic [IDX_W-1:0]    eidx_e;
	logic [EXP_W-1:0]    eexp_e;

	logic                ranked;
	logic                rank_mis;
	logic                chk;
	logic                take_mask;
	logic [DIM_BITS-1:0] dim_v [LANES];
	logic [LANES-1:0]    act;
	logic [LANES-1:0]    mis;
	logic [LANES-1:0]    err_vec;
	logic [LANES-1:0]    err_low;
	logic [LANES-1:0]    allowed;
	logic [LANES-1:0]    store;
	logic [IDX_W-1:0]    first_idx;
	logic [IDX_W-1:0]    err_idx;
	logic [63:0]         exp_wide;

	logic                rk_n;
	logic [RANK_W-1:0]   srank_n;
	logic                mask_n;
	logic [IDX_W-1:0]    masked_n;
	logic [STAT_W-1:0]   err_n;
	logic [IDX_W-1:0]    eidx_n;
	logic [EXP_W-1:0]    eexp_n;

	// Configuration register; the user writes it only while the block is idle (not enforced).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_q <= 1'b0;
		end else if (cfg_valid) begin
			allow_q <= cfg_data;
		end
	end

	// Operand capture.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			start_q  <= s_tuser[tscc_pkg::TUSER_START];
			ranked_q <= s_tuser[tscc_pkg::TUSER_RANKED];
			rank_q   <= s_tdata[RANK_W-1:0];
			for (int i = 0; i < LANES; i++) begin
				dim_in_q[i] <= s_tdata[RANK_W + i*DIN_W +: DIN_W];
			end
		end
	end

	// Apply a start of list to the state before checking.
	always_comb begin
		rk_e     = start_q ? 1'b0 : rank_known_q;
		srank_e  = start_q ? '0 : stored_rank_q;
		mask_e   = start_q ? 1'b0 : mask_active_q;
		masked_e = start_q ? '0 : masked_dim_q;
		err_e    = start_q ? tscc_pkg::STAT_OK : err_status_q;
		eidx_e   = start_q ? '0 : err_index_q;
		eexp_e   = start_q ? '0 : err_expected_q;
		for (int i = 0; i < LANES; i++) begin
			sdim_e[i] = start_q ? DIM_UNK : stored_dims_q[i];
		end
	end

	// Rank check; a latched error freezes the list.
	assign ranked    = ranked_q && (err_e == tscc_pkg::STAT_OK);
	assign rank_mis  = ranked && rk_e && (srank_e != rank_q);
	assign chk       = ranked && !rank_mis;
	assign take_mask = allow_q && !mask_e;

	// Per-lane compare of incoming size against the stored size.
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		logic signed [63:0] dim_ext;
		assign dim_ext  = 64'(signed'(dim_in_q[g]));
		assign dim_v[g] = dim_ext[DIM_BITS-1:0];
		if (g < MAX_RANK) begin : g_used
			assign act[g] = chk && (RANK_W'(g) < rank_q)
				&& !(mask_e && (masked_e == IDX_W'(g)))
				&& (dim_v[g] != DIM_UNK);
		end else begin : g_unused
			assign act[g] = 1'b0;
		end
		assign mis[g]   = act[g] && (sdim_e[g] != DIM_UNK) && (sdim_e[g] != dim_v[g]);
		assign store[g] = act[g] && (sdim_e[g] == DIM_UNK) && allowed[g];
	end

	// Priority pick: with a mask available, the first mismatch is masked and the second errors.
	assign err_vec   = take_mask ? (mis & (mis - LANES'(1))) : mis;
	assign err_low   = err_vec & (~err_vec + LANES'(1));
	assign allowed   = (err_vec == '0) ? '1 : (err_low - LANES'(1));
	assign first_idx = tscc_pkg::lowest_index(mis);
	assign err_idx   = tscc_pkg::lowest_index(err_vec);
	assign exp_wide  = 64'(sdim_e[err_idx]);

	// Next list state.
	always_comb begin
		rk_n     = rk_e || ranked;
		srank_n  = (ranked && !rk_e) ? rank_q : srank_e;
		mask_n   = mask_e;
		masked_n = masked_e;
		err_n    = err_e;
		eidx_n   = eidx_e;
		eexp_n   = eexp_e;
		if (rank_mis) begin
			err_n  = tscc_pkg::STAT_RANK;
			eidx_n = '0;
			eexp_n = EXP_W'(srank_e);
		end else if (chk) begin
			if (take_mask && (mis != '0)) begin
				mask_n   = 1'b1;
				masked_n = first_idx;
			end
			if (err_vec != '0) begin
				err_n  = tscc_pkg::STAT_DIM;
				eidx_n = err_idx;
				eexp_n = exp_wide[EXP_W-1:0];
			end
		end
	end

	// List state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_known_q   <= 1'b0;
			stored_rank_q  <= '0;
			mask_active_q  <= 1'b0;
			masked_dim_q   <= '0;
			err_status_q   <= tscc_pkg::STAT_OK;
			err_index_q    <= '0;
			err_expected_q <= '0;
			for (int i = 0; i < LANES; i++) begin
				stored_dims_q[i] <= DIM_UNK;
			end
		end else if (cmd.commit) begin
			rank_known_q   <= rk_n;
			stored_rank_q  <= srank_n;
			mask_active_q  <= mask_n;
			masked_dim_q   <= masked_n;
			err_status_q   <= err_n;
			err_index_q    <= eidx_n;
			err_expected_q <= eexp_n;
			for (int i = 0; i < LANES; i++) begin
				stored_dims_q[i] <= store[i] ? dim_v[i] : sdim_e[i];
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_status_q   <= err_n;
			res_index_q    <= eidx_n;
			res_expected_q <= eexp_n;
		end
	end

	assign m_tdata = {3'b000, res_expected_q, res_index_q, res_status_q};

endmodule

FILE: rtl/core/tensor_shape_compat_checker_core.sv
// Top level of the tensor shape compatibility checker.
//
// Operand shapes arrive one per request on the slave stream (s_*), and each
// request yields one running status on the master stream (m_*). A request
// with the start flag set in s_tuser clears the stored shape, the mask and
// any latched error before it is checked. The one-mismatch option is set by
// a write on the cfg channel, which is always ready.
//
// An accepted request waits in the operand register and its status is loaded
// into the result register once that is free. Throughput: one request per
// cycle unless the receiver stalls, because all eight lanes are compared in
// parallel and the first mismatch is taken by a combinational priority pick.
//
// Reset clears the option, the stored shape (all sizes unknown) and the
// error state. When the receiver stalls, one request waits in the operand
// register and one result waits in the output register; s_tready drops
// until the held request can commit.
module tensor_shape_compat_checker_core #(
	parameter int MAX_RANK = 8,
	parameter int DIM_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// rank[3:0], dim_0[35:4], dim_1 .. dim_7 in 32-bit steps up to [259:228], zeros above
	input  logic [tscc_pkg::S_TDATA_W-1:0]   s_tdata,
	// start_list[0], is_ranked[1]
	input  logic [tscc_pkg::S_TUSER_W-1:0]   s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// status[1:0], bad_index[4:2], expected_value[36:5], zeros above
	output logic [tscc_pkg::M_TDATA_W-1:0]   m_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic                             cfg_data
);

	tscc_pkg::cmd_t cmd;

	assign cfg_ready = 1'b1;

	tscc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	tscc_datapath #(
		.MAX_RANK (MAX_RANK),
		.DIM_BITS (DIM_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tdata   (m_tdata)
	);

endmodule

FILE: rtl/core/tscc_checker.sv
// Port-level checker for the tensor shape compatibility checker, bound to the top level.
module tscc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [tscc_pkg::M_TDATA_W-1:0]   m_tdata
);

	// A result that is not taken stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result request dropped while stalled");

	// The status code is never the unused encoding.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] == tscc_pkg::STAT_OK)
			|| (m_tdata[1:0] == tscc_pkg::STAT_RANK)
			|| (m_tdata[1:0] == tscc_pkg::STAT_DIM))
		else $error("invalid status code");

	// A compatible result carries no error details.
	a_ok_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == tscc_pkg::STAT_OK) |-> (m_tdata[36:2] == '0))
		else $error("error details present with compatible status");

	// A rank mismatch reports dimension index zero.
	a_rank_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == tscc_pkg::STAT_RANK) |-> (m_tdata[4:2] == '0))
		else $error("rank mismatch with nonzero index");

endmodule

bind tensor_shape_compat_checker_core tscc_checker u_tscc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: verif/tb.sv
// Self-checking testbench for the tensor shape compatibility checker core.
module tb;

	localparam int LANES     = tscc_pkg::LANES;
	localparam int RANK_W    = tscc_pkg::RANK_W;
	localparam int IDX_W     = tscc_pkg::IDX_W;
	localparam int DIM_IN_W  = tscc_pkg::DIM_IN_W;
	localparam int STATUS_W  = tscc_pkg::STATUS_W;
	localparam int EXP_W     = tscc_pkg::EXP_W;
	localparam int S_TDATA_W = tscc_pkg::S_TDATA_W;
	localparam int S_TUSER_W = tscc_pkg::S_TUSER_W;
	localparam int M_TDATA_W = tscc_pkg::M_TDATA_W;

	localparam logic [STATUS_W-1:0] STAT_OK   = tscc_pkg::STAT_OK;
	localparam logic [STATUS_W-1:0] STAT_RANK = tscc_pkg::STAT_RANK;
	localparam logic [STATUS_W-1:0] STAT_DIM  = tscc_pkg::STAT_DIM;

	localparam logic [DIM_IN_W-1:0] SIZE_UNKNOWN = '1;
	localparam logic [DIM_IN_W-1:0] SIZE_MAX     = 32'h7FFF_FFFF;

	// One operand request and one running status, at the block's field widths.
	typedef struct packed {
		logic                               start;
		logic                               ranked;
		logic [RANK_W-1:0]                  rank;
		logic [LANES-1:0][DIM_IN_W-1:0]     dims;
	} operand_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [IDX_W-1:0]    bad_index;
		logic [EXP_W-1:0]    expected_value;
	} shape_status_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [S_TUSER_W-1:0] s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic                 cfg_data = 1'b0;

	// Mirror of the checker state, updated as each request is accepted.
	logic                           opt_allow_one;
	logic                           shape_rank_known;
	logic [RANK_W-1:0]              shape_rank;
	logic [LANES-1:0][DIM_IN_W-1:0] shape_dims;
	logic                           mask_on;
	logic [IDX_W-1:0]               mask_lane;
	logic [STATUS_W-1:0]            latched_status;
	logic [IDX_W-1:0]               latched_index;
	logic [EXP_W-1:0]               latched_expected;

	shape_status_t pending_status_q[$];
	int            n_fail = 0;
	bit            sender_steady = 1'b0;
	bit            receiver_steady = 1'b0;

	tensor_shape_compat_checker_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Start of a new list: nothing stored, no mask, no latched error.
	task automatic clear_shape();
		shape_rank_known = 1'b0;
		shape_rank       = '0;
		shape_dims       = {LANES{SIZE_UNKNOWN}};
		mask_on          = 1'b0;
		mask_lane        = '0;
		latched_status   = STAT_OK;
		latched_index    = '0;
		latched_expected = '0;
	endtask

	// Applies one operand to the mirrored shape and queues the status it yields.
	task automatic shape_check_step(input operand_t op);
		bit            stop;
		int            lim;
		logic [31:0]   d;
		shape_status_t res;
		if (op.start) begin
			clear_shape();
		end
		if (latched_status == STAT_OK && op.ranked) begin
			if (!shape_rank_known) begin
				shape_rank_known = 1'b1;
				shape_rank = op.rank;
			end
			if (shape_rank != op.rank) begin
				latched_status   = STAT_RANK;
				latched_index    = '0;
				latched_expected = EXP_W'(shape_rank);
			end else begin
				stop = 1'b0;
				lim = (op.rank < LANES) ? int'(op.rank) : LANES;
				for (int i = 0; i < LANES; i++) begin
					d = op.dims[i];
					// Lanes past the rank, the masked lane and unknown sizes are skipped.
					if (!stop && i < lim && !(mask_on && mask_lane == i) && d != SIZE_UNKNOWN) begin
						if (shape_dims[i] == SIZE_UNKNOWN) begin
							shape_dims[i] = d;
						end else if (shape_dims[i] != d) begin
							if (opt_allow_one && !mask_on) begin
								mask_on = 1'b1;
								mask_lane = IDX_W'(i);
							end else begin
								latched_status   = STAT_DIM;
								latched_index    = IDX_W'(i);
								latched_expected = shape_dims[i];
								stop = 1'b1;
							end
						end
					end
				end
			end
		end
		res.status         = latched_status;
		res.bad_index      = latched_index;
		res.expected_value = latched_expected;
		pending_status_q.push_back(res);
	endtask

	// Sends one request, entered and left at a falling edge.
	task automatic send_operand(input operand_t op);
		int gap;
		gap = sender_steady ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, op.dims, op.rank};
		s_tuser  <= {op.ranked, op.start};
		do @(posedge clk); while (!s_tready);
		shape_check_step(op);
		@(negedge clk);
	endtask

	// Writes the one-mismatch option; only called while the block is idle.
	task automatic write_option(input logic value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		opt_allow_one = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Holds off the sender until every queued status has come back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_status_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (3) @(negedge clk);
	endtask

	// Draws a size within the field's range, weighted toward the extremes.
	function automatic logic [31:0] pick_size();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return SIZE_MAX;
			2: return 32'($urandom_range(1, 16));
			3: return $urandom & SIZE_MAX;
			4: return SIZE_UNKNOWN;
			default: return 32'($urandom_range(1, 4));
		endcase
	endfunction

	// Builds a request with the first four sizes given and junk in the upper lanes.
	function automatic operand_t shape(input bit st, input bit rk, input int r,
			input int d0, input int d1, input int d2, input int d3);
		operand_t op;
		op.start  = st;
		op.ranked = rk;
		op.rank   = RANK_W'(r);
		op.dims[0] = d0;
		op.dims[1] = d1;
		op.dims[2] = d2;
		op.dims[3] = d3;
		for (int i = 4; i < LANES; i++) begin
			op.dims[i] = pick_size();
		end
		return op;
	endfunction

	// Rank and size checks, latching, unranked operands and list restart.
	task automatic test_shape_basics();
		operand_t op;
		send_operand(shape(1, 1, 3, 2, -1, 5, 9));
		send_operand(shape(0, 1, 3, 2, 4, 5, -1));
		send_operand(shape(0, 0, 6, 7, 7, 7, 7));
		send_operand(shape(0, 1, 3, -1, -1, -1, 0));
		send_operand(shape(0, 1, 3, 2, 4, 6, 1));
		send_operand(shape(0, 1, 2, 1, 1, 1, 1));
		send_operand(shape(1, 0, 8, 0, 0, 0, 0));
		// Full rank at the largest size, then a zero in the top lane.
		op = shape(1, 1, 8, SIZE_MAX, SIZE_MAX, SIZE_MAX, SIZE_MAX);
		for (int i = 4; i < LANES; i++) begin
			op.dims[i] = SIZE_MAX;
		end
		send_operand(op);
		op.start = 1'b0;
		op.dims[7] = '0;
		send_operand(op);
		send_operand(shape(1, 1, 0, 3, 3, 3, 3));
		send_operand(shape(0, 1, 8, 3, 3, 3, 3));
		send_operand(shape(1, 1, 4, 0, 0, 0, 0));
		send_operand(shape(0, 1, 5, 0, 0, 0, 0));
	endtask

	// Masking of the first mismatching lane, and a second mismatch in one operand.
	task automatic test_mask_option();
		send_operand(shape(1, 1, 4, 1, 2, 3, 4));
		send_operand(shape(0, 1, 4, 9, 2, 3, 4));
		send_operand(shape(0, 1, 4, 7, 2, 3, 4));
		send_operand(shape(0, 1, 4, 1, 2, 3, 5));
		send_operand(shape(1, 1, 3, 1, 1, 1, 0));
		send_operand(shape(0, 1, 3, 2, 2, 1, 0));
		send_operand(shape(1, 1, 2, -1, 5, 0, 0));
		send_operand(shape(0, 1, 2, 0, -1, 0, 0));
	endtask

	// Random lists built around a base shape, with some noise requests in between.
	task automatic test_random_lists(input int n_items);
		int            sent;
		int            len;
		int            base_rank;
		int            pick;
		logic [31:0]   base[LANES];
		operand_t      op;
		sent = 0;
		while (sent < n_items) begin
			sender_steady   = ($urandom_range(0, 9) == 0);
			receiver_steady = ($urandom_range(0, 9) == 0);
			if ($urandom_range(0, 9) == 0) begin
				op.start  = 1'($urandom_range(0, 1));
				op.ranked = 1'($urandom_range(0, 1));
				op.rank   = RANK_W'($urandom_range(0, LANES));
				for (int i = 0; i < LANES; i++) begin
					op.dims[i] = pick_size();
				end
				send_operand(op);
				sent++;
			end else begin
				base_rank = $urandom_range(0, LANES);
				for (int i = 0; i < LANES; i++) begin
					base[i] = pick_size();
				end
				len = $urandom_range(1, 8);
				for (int k = 0; k < len; k++) begin
					op.start  = (k == 0) || ($urandom_range(0, 29) == 0);
					op.ranked = ($urandom_range(0, 9) != 0);
					op.rank   = ($urandom_range(0, 19) == 0) ?
						RANK_W'($urandom_range(0, LANES)) : RANK_W'(base_rank);
					for (int i = 0; i < LANES; i++) begin
						pick = $urandom_range(0, 9);
						if (pick < 6) begin
							op.dims[i] = base[i];
						end else if (pick < 8) begin
							op.dims[i] = SIZE_UNKNOWN;
						end else if (pick == 8) begin
							op.dims[i] = pick_size();
						end else begin
							op.dims[i] = (base[i] == SIZE_MAX || base[i] == SIZE_UNKNOWN) ?
								32'd3 : base[i] + 32'd1;
						end
					end
					send_operand(op);
					sent++;
				end
			end
		end
		sender_steady   = 1'b0;
		receiver_steady = 1'b0;
	endtask

	// Compares one received status with the oldest one queued.
	task automatic check_status(input logic [M_TDATA_W-1:0] word);
		shape_status_t want;
		if (pending_status_q.size() == 0) begin
			$error("result with nothing queued: tdata %h", word);
			n_fail++;
		end else begin
			want = pending_status_q.pop_front();
			if (word[1:0] !== want.status) begin
				$error("field status expected %0d got %0d", want.status, word[1:0]);
				n_fail++;
			end
			if (word[4:2] !== want.bad_index) begin
				$error("field bad_index expected %0d got %0d", want.bad_index, word[4:2]);
				n_fail++;
			end
			if (word[36:5] !== want.expected_value) begin
				$error("field expected_value expected %0d got %0d",
					$signed(want.expected_value), $signed(word[36:5]));
				n_fail++;
			end
		end
	endtask

	// Receiver: random stall before each result, then check it on acceptance.
	initial begin
		int stall;
		@(negedge clk);
		forever begin
			stall = receiver_steady ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
			check_status(m_tdata);
			@(negedge clk);
		end
	end

	// Sequence of tests.
	initial begin
		int waited;
		opt_allow_one = 1'b0;
		clear_shape();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_shape_basics();
		drain_results();
		write_option(1'b1);
		test_mask_option();
		drain_results();

		write_option(1'b0);
		test_random_lists(600);
		drain_results();
		write_option(1'b1);
		test_random_lists(600);
		drain_results();
		write_option(1'b0);
		test_random_lists(530);

		s_tvalid <= 1'b0;
		waited = 0;
		while (pending_status_q.size() != 0 && waited < 1000) begin
			@(posedge clk);
			waited++;
		end
		repeat (5) @(posedge clk);
		if (pending_status_q.size() != 0) begin
			$error("%0d results never arrived", pending_status_q.size());
			n_fail++;
		end
		if (n_fail == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/tscc_pkg.sv
rtl/core/tscc_ctrl.sv
rtl/core/tscc_datapath.sv
rtl/core/tensor_shape_compat_checker_core.sv
rtl/core/tscc_checker.sv
verif/tb.sv
